### sv/bcpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the block cipher padding engine.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int RESULT_LEN_W = 17;
    localparam int PAD_CNT_W    = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 3;
    localparam int JOB_DEPTH    = 4;
    localparam int JOB_PTR_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PAD_SCHEME     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REMOVE_PADDING = 2'd1;

    localparam logic [2:0] SCHEME_BLOCK  = 3'd0;
    localparam logic [2:0] SCHEME_PKCS7  = 3'd1;
    localparam logic [2:0] SCHEME_M1     = 3'd2;
    localparam logic [2:0] SCHEME_M2     = 3'd3;
    localparam logic [2:0] SCHEME_STREAM = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_LENGTH   = 2'd1;
    localparam logic [1:0] STATUS_BAD_PAD  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [7:0] M2_MARKER = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } request_t;

    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    end_of_message;
        logic [1:0]              status;
        logic [RESULT_LEN_W-1:0] result_length;
    } result_t;

    // One classified byte, handed from the front to the back
    typedef struct packed {
        logic [7:0]              data_byte;
        logic                    last;
        logic [PAD_CNT_W-1:0]    pad_cnt;
        logic [7:0]              pad_first;
        logic [7:0]              pad_rest;
        logic [1:0]              status;
        logic [RESULT_LEN_W-1:0] length;
    } job_t;

endpackage

### sv/block_cipher_padding_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cipher_padding_engine_core
// Pads or strips padding of a byte stream to cipher blocks (block no-pad,
// PKCS7, ISO9797 M1 and M2, stream pass-through).
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  request   | push / full           | data_byte, last_byte
//  result    | pop / empty           | out_byte, end_of_message, status,
//            |                       | result_length
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request per cycle while the job queue is not full; the back emits one
//  result per cycle while pop does not stall, echo first and then any padding.
//  A four-entry job queue between front and back absorbs that padding burst.
//  Each accepted request passes the job queue, then the result register.
//  Reset clears the message trackers and queues; registers reset to zero.
//  A stalled pop holds the result register and backs up into the queue.
// ----------------------------------------------------------------------------
module block_cipher_padding_engine_core
    import bcpe_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 65536,
    parameter int BLOCK_BYTES       = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  request_t               request,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic job_full;
    logic job_empty;
    logic job_push;
    logic job_pop;
    job_t job_in;
    job_t job_head;

    assign full = job_full;

    bcpe_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .BLOCK_BYTES       (BLOCK_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .request   (request),
        .job_full  (job_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    bcpe_job_fifo u_job_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .full   (job_full),
        .rd_en  (job_pop),
        .rd_job (job_head),
        .empty  (job_empty)
    );

    bcpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### sv/bcpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_front
// Accepts message bytes, tracks length and trailing bytes, and classifies
// each byte into a job: status, result length and padding to append.
// ----------------------------------------------------------------------------
module bcpe_front
    import bcpe_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 65536,
    parameter int BLOCK_BYTES       = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  request_t               request,
    input  logic                   job_full,
    output logic                   job_push,
    output job_t                   job
);

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 3);
    localparam int POS_W = $clog2(BLOCK_BYTES);
    localparam int LEN_W = (CNT_W + 1 > RESULT_LEN_W) ? CNT_W + 1 : RESULT_LEN_W;
    localparam logic [CNT_W-1:0]     MAX_CNT  = CNT_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0]     BLK_LAST = POS_W'(BLOCK_BYTES - 1);
    localparam logic [PAD_CNT_W-1:0] BLK      = PAD_CNT_W'(BLOCK_BYTES);
    localparam logic [7:0]           BLK_BYTE = 8'(BLOCK_BYTES);

    logic [2:0]       pad_scheme_reg;
    logic             remove_padding_reg;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [POS_W-1:0] blk_pos_reg, blk_pos_next;
    logic [CNT_W-1:0] nonzero_end_reg, nonzero_end_next;
    logic [CNT_W-1:0] marker_end_reg, marker_end_next;
    logic             marker_ok_reg, marker_ok_next;
    logic [7:0]       recent_reg [BLOCK_BYTES];

    logic                 accept;
    logic [7:0]           data;
    logic [CNT_W-1:0]     n;
    logic [POS_W-1:0]     rem;
    logic                 rem_zero;
    logic [PAD_CNT_W-1:0] pad_full;
    logic [2:0]           scheme_eff;
    logic                 data_nz;
    logic [CNT_W-1:0]     nz_end_upd;
    logic [CNT_W-1:0]     mk_end_upd;
    logic                 mk_ok_upd;
    logic                 p_ok;
    logic                 run_ok;
    logic [1:0]           st;
    logic [LEN_W-1:0]     len;
    logic [PAD_CNT_W-1:0] pad_cnt;
    logic [7:0]           pad_first;
    logic [7:0]           pad_rest;

    assign cfg_ready = 1'b1;
    assign accept    = push & ~job_full;
    assign job_push  = accept;
    assign data      = request.data_byte;

    assign n          = byte_count_reg + CNT_W'(1);
    assign rem        = (blk_pos_reg == BLK_LAST) ? '0 : blk_pos_reg + POS_W'(1);
    assign rem_zero   = (rem == '0);
    assign pad_full   = BLK - PAD_CNT_W'(rem);
    assign scheme_eff = (pad_scheme_reg > SCHEME_STREAM) ? SCHEME_STREAM : pad_scheme_reg;
    assign data_nz    = (data != 8'd0);
    assign nz_end_upd = data_nz ? n : nonzero_end_reg;
    assign mk_end_upd = data_nz ? byte_count_reg : marker_end_reg;
    assign mk_ok_upd  = data_nz ? (data == M2_MARKER) : marker_ok_reg;
    assign p_ok       = data_nz && (data <= BLK_BYTE) && (LEN_W'(data) <= LEN_W'(n));

    // PKCS7 trailing run: every byte inside the pad length must equal it
    always_comb
    begin
        run_ok = 1'b1;
        for (int i = 1; i < BLOCK_BYTES; i++)
        begin
            if ((8'(i) < data) && (recent_reg[i-1] != data))
            begin
                run_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        st        = STATUS_OK;
        len       = '0;
        pad_cnt   = '0;
        pad_first = 8'd0;
        pad_rest  = 8'd0;
        if (n > MAX_CNT)
        begin
            st = STATUS_OVERFLOW;
        end
        else if (!remove_padding_reg)
        begin
            unique case (scheme_eff)
                SCHEME_BLOCK:
                begin
                    if (!rem_zero)
                    begin
                        st = STATUS_LENGTH;
                    end
                    else
                    begin
                        len = LEN_W'(n);
                    end
                end
                SCHEME_PKCS7:
                begin
                    pad_cnt   = pad_full;
                    pad_first = 8'(pad_full);
                    pad_rest  = 8'(pad_full);
                    len       = LEN_W'(n) + LEN_W'(pad_full);
                end
                SCHEME_M1:
                begin
                    pad_cnt = rem_zero ? '0 : pad_full;
                    len     = LEN_W'(n) + LEN_W'(rem_zero ? '0 : pad_full);
                end
                SCHEME_M2:
                begin
                    pad_cnt   = pad_full;
                    pad_first = M2_MARKER;
                    len       = LEN_W'(n) + LEN_W'(pad_full);
                end
                default:
                begin
                    len = LEN_W'(n);
                end
            endcase
        end
        else if (scheme_eff != SCHEME_STREAM && !rem_zero)
        begin
            st = STATUS_LENGTH;
        end
        else
        begin
            unique case (scheme_eff)
                SCHEME_PKCS7:
                begin
                    if (p_ok && run_ok)
                    begin
                        len = LEN_W'(n) - LEN_W'(data);
                    end
                    else
                    begin
                        st = STATUS_BAD_PAD;
                    end
                end
                SCHEME_M1:
                begin
                    len = LEN_W'(nz_end_upd);
                end
                SCHEME_M2:
                begin
                    if (mk_ok_upd)
                    begin
                        len = LEN_W'(mk_end_upd);
                    end
                    else
                    begin
                        st = STATUS_BAD_PAD;
                    end
                end
                default:
                begin
                    len = LEN_W'(n);
                end
            endcase
        end
        if (st != STATUS_OK)
        begin
            len     = '0;
            pad_cnt = '0;
        end
    end

    always_comb
    begin
        job.data_byte = data;
        job.last      = request.last_byte;
        job.pad_first = pad_first;
        job.pad_rest  = pad_rest;
        if (request.last_byte)
        begin
            job.pad_cnt = pad_cnt;
            job.status  = st;
            job.length  = len[RESULT_LEN_W-1:0];
        end
        else
        begin
            job.pad_cnt = '0;
            job.status  = STATUS_OK;
            job.length  = '0;
        end
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        blk_pos_next     = blk_pos_reg;
        nonzero_end_next = nonzero_end_reg;
        marker_end_next  = marker_end_reg;
        marker_ok_next   = marker_ok_reg;
        if (accept)
        begin
            if (request.last_byte)
            begin
                byte_count_next  = '0;
                blk_pos_next     = '0;
                nonzero_end_next = '0;
                marker_end_next  = '0;
                marker_ok_next   = 1'b0;
            end
            else
            begin
                // hold the count one past the limit
                if (byte_count_reg <= MAX_CNT)
                begin
                    byte_count_next = n;
                end
                blk_pos_next     = rem;
                nonzero_end_next = nz_end_upd;
                marker_end_next  = mk_end_upd;
                marker_ok_next   = mk_ok_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_scheme_reg     <= SCHEME_BLOCK;
            remove_padding_reg <= 1'b0;
            byte_count_reg     <= '0;
            blk_pos_reg        <= '0;
            nonzero_end_reg    <= '0;
            marker_end_reg     <= '0;
            marker_ok_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PAD_SCHEME:     pad_scheme_reg     <= cfg_data;
                    REG_REMOVE_PADDING: remove_padding_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
            byte_count_reg  <= byte_count_next;
            blk_pos_reg     <= blk_pos_next;
            nonzero_end_reg <= nonzero_end_next;
            marker_end_reg  <= marker_end_next;
            marker_ok_reg   <= marker_ok_next;
        end
    end

    // Shift line of recent bytes, newest at index 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            recent_reg[0] <= data;
            for (int i = 1; i < BLOCK_BYTES; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

endmodule

### sv/bcpe_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_job_fifo
// Short queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module bcpe_job_fifo
    import bcpe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_PTR_W:0]   count_reg, count_next;
    job_t                 entry_reg [JOB_DEPTH];

    logic do_wr;
    logic do_rd;

    assign full   = (count_reg == (JOB_PTR_W + 1)'(JOB_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en & ~full;
    assign do_rd  = rd_en & ~empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + JOB_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + JOB_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (JOB_PTR_W + 1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (JOB_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### sv/bcpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpe_back
// Expands each job into its echoed byte and any padding bytes, one result
// per cycle while the output register is free or popped, into that register.
// ----------------------------------------------------------------------------
module bcpe_back
    import bcpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_empty,
    input  job_t    job_head,
    output logic    job_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic                 have_job_reg, have_job_next;
    job_t                 job_reg;
    logic [PAD_CNT_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg;

    logic                 advance;
    logic                 src_valid;
    job_t                 src;
    logic [PAD_CNT_W-1:0] idx;
    logic                 done;
    logic                 fire;
    logic                 eom;
    result_t              res;

    assign advance   = ~out_valid_reg | pop;
    assign src_valid = have_job_reg | ~job_empty;
    assign src       = have_job_reg ? job_reg : job_head;
    assign idx       = have_job_reg ? idx_reg : '0;
    assign done      = (idx == src.pad_cnt);
    assign fire      = advance & src_valid;
    assign job_pop   = fire & ~have_job_reg;
    assign empty     = ~out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        if (idx == '0)
        begin
            res.out_byte = src.data_byte;
            eom          = src.last & (src.pad_cnt == '0);
        end
        else
        begin
            res.out_byte = (idx == PAD_CNT_W'(1)) ? src.pad_first : src.pad_rest;
            eom          = done;
        end
        res.end_of_message = eom;
        res.status         = eom ? src.status : STATUS_OK;
        res.result_length  = eom ? src.length : '0;
    end

    always_comb
    begin
        have_job_next  = have_job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg & ~pop;
        if (fire)
        begin
            have_job_next  = ~done;
            idx_next       = idx + PAD_CNT_W'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_job_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_job_reg  <= have_job_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // capture each popped job; it is used while padding remains to emit
        if (job_pop)
        begin
            job_reg <= job_head;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

endmodule

### tb/sv/tb_block_cipher_padding_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_cipher_padding_engine_core
// Self-checking bench for the padding engine. A short table of hand-picked
// requests runs first, then random messages that are mostly well formed for
// the active scheme. Every accepted result is compared with the output of a
// local padding predictor.
// ----------------------------------------------------------------------------
module tb_block_cipher_padding_engine_core;
    import bcpe_pkg::*;

    localparam int MAX_MSG      = 65536;
    localparam int BLOCK        = 16;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int IDLE_SETTLE  = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 360;
    localparam int NUM_STEPS    = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [2:0] SCHEME_SPARE_5 = 3'd5;
    localparam logic [2:0] SCHEME_SPARE_6 = 3'd6;
    localparam logic [2:0] SCHEME_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                    set_cfg;
        logic [2:0]              scheme;
        logic                    remove;
        logic [7:0]              data_byte;
        logic                    last_byte;
        logic                    typed;
        logic [1:0]              status;
        logic [RESULT_LEN_W-1:0] length;
    } step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    request_t               request;
    logic                   empty;
    logic                   pop;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the registers and message trackers
    logic [2:0]              cur_scheme;
    logic                    cur_remove;
    logic [RESULT_LEN_W-1:0] msg_count;
    logic [7:0]              tail_bytes [BLOCK];
    logic [RESULT_LEN_W-1:0] nonzero_end;
    logic [RESULT_LEN_W-1:0] marker_pos;
    logic                    marker_seen;

    result_t    queued_outputs [$];
    logic [7:0] msg_buf [$];
    step_t      plan [NUM_STEPS];

    int  errs;
    int  items_sent;
    int  burst_left;
    int  cycles;
    int  hold_left;
    int  rx_tick;
    int  rx_mode;
    logic hold_req;
    logic hold_started;

    block_cipher_padding_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        errs++;
        if (errs <= 200)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Compute the results that one accepted byte causes and queue them
    task automatic pad_predict(input request_t r, input logic typed,
                               input logic [1:0] t_st, input logic [RESULT_LEN_W-1:0] t_len);
        logic [RESULT_LEN_W-1:0] n;
        logic [RESULT_LEN_W-1:0] len;
        logic [1:0]              st;
        logic [2:0]              sch;
        logic [7:0]              pad_first;
        logic [7:0]              pad_rest;
        logic [7:0]              p;
        result_t                 res;
        int                      rem;
        int                      pad_cnt;
        int                      i;
        n = msg_count + 1'b1;
        sch = (cur_scheme > SCHEME_STREAM) ? SCHEME_STREAM : cur_scheme;
        st = STATUS_OK;
        len = '0;
        pad_cnt = 0;
        pad_first = '0;
        pad_rest = '0;
        for (i = BLOCK - 1; i > 0; i--)
            tail_bytes[i] = tail_bytes[i - 1];
        tail_bytes[0] = r.data_byte;
        if (r.data_byte != 8'h00)
        begin
            nonzero_end = n;
            marker_pos = n - 1'b1;
            marker_seen = (r.data_byte == M2_MARKER);
        end
        if (msg_count <= MAX_MSG)
            msg_count = n;
        if (!r.last_byte)
        begin
            res = '{out_byte: r.data_byte, end_of_message: 1'b0, status: STATUS_OK,
                    result_length: '0};
            queued_outputs.push_back(res);
            return;
        end
        rem = int'(n) % BLOCK;
        if (n > MAX_MSG)
            st = STATUS_OVERFLOW;
        else if (!cur_remove)
        begin
            case (sch)
                SCHEME_BLOCK:
                begin
                    if (rem != 0)
                        st = STATUS_LENGTH;
                    else
                        len = n;
                end
                SCHEME_PKCS7:
                begin
                    pad_cnt = BLOCK - rem;
                    pad_first = 8'(pad_cnt);
                    pad_rest = 8'(pad_cnt);
                end
                SCHEME_M1:
                    pad_cnt = (rem != 0) ? BLOCK - rem : 0;
                SCHEME_M2:
                begin
                    pad_cnt = BLOCK - rem;
                    pad_first = M2_MARKER;
                end
                default:
                    len = n;
            endcase
            if (st == STATUS_OK && sch != SCHEME_BLOCK && sch != SCHEME_STREAM)
                len = n + RESULT_LEN_W'(pad_cnt);
        end
        else if (sch != SCHEME_STREAM && rem != 0)
            st = STATUS_LENGTH;
        else if (sch == SCHEME_PKCS7)
        begin
            p = r.data_byte;
            if (p == 0 || p > BLOCK || p > n)
                st = STATUS_BAD_PAD;
            else
            begin
                for (i = 0; i < int'(p); i++)
                    if (tail_bytes[i] != p)
                        st = STATUS_BAD_PAD;
                if (st == STATUS_OK)
                    len = n - p;
            end
        end
        else if (sch == SCHEME_M1)
            len = nonzero_end;
        else if (sch == SCHEME_M2)
        begin
            if (marker_seen)
                len = marker_pos;
            else
                st = STATUS_BAD_PAD;
        end
        else
            len = n;
        if (st != STATUS_OK)
        begin
            len = '0;
            pad_cnt = 0;
        end
        if (typed)
        begin
            st = t_st;
            len = t_len;
        end
        res = '{out_byte: r.data_byte, end_of_message: (pad_cnt == 0),
                status: (pad_cnt == 0) ? st : STATUS_OK,
                result_length: (pad_cnt == 0) ? len : '0};
        queued_outputs.push_back(res);
        for (i = 0; i < pad_cnt; i++)
        begin
            res.out_byte = (i == 0) ? pad_first : pad_rest;
            res.end_of_message = (i + 1 == pad_cnt);
            res.status = (i + 1 == pad_cnt) ? st : STATUS_OK;
            res.result_length = (i + 1 == pad_cnt) ? len : '0;
            queued_outputs.push_back(res);
        end
        msg_count = '0;
        nonzero_end = '0;
        marker_pos = '0;
        marker_seen = 1'b0;
    endtask

    // Offer one request, idling between bursts, and predict once accepted
    task automatic send_byte(input request_t r, input logic typed,
                             input logic [1:0] t_st, input logic [RESULT_LEN_W-1:0] t_len);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (hold_left != 0) ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        pad_predict(r, typed, t_st, t_len);
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_buf.size(); i++)
            send_byte('{data_byte: msg_buf[i], last_byte: (i == msg_buf.size() - 1)},
                      1'b0, STATUS_OK, '0);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (queued_outputs.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input logic more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_PAD_SCHEME)
            cur_scheme = val;
        else if (idx == REG_REMOVE_PADDING)
            cur_remove = val[0];
        // hold valid when another write follows at once
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0, 1:    return 8'h00;
            2:       return M2_MARKER;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Fill msg_buf with a message shaped for the active scheme and direction
    task automatic build_message();
        logic [2:0] sch;
        int         how;
        int         len;
        int         p;
        int         k;
        int         i;
        msg_buf.delete();
        sch = (cur_scheme > SCHEME_STREAM) ? SCHEME_STREAM : cur_scheme;
        how = $urandom_range(0, 4);
        len = ($urandom_range(0, 5) == 0) ? 2 * BLOCK : BLOCK;
        if (!cur_remove)
        begin
            if (sch != SCHEME_BLOCK || how == 0)
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 16);
            for (i = 0; i < len; i++)
                msg_buf.push_back(rand_byte());
            return;
        end
        case (sch)
            SCHEME_PKCS7:
            begin
                p = $urandom_range(1, BLOCK);
                for (i = 0; i < len - p; i++)
                    msg_buf.push_back(rand_byte());
                for (i = 0; i < p; i++)
                    msg_buf.push_back(8'(p));
                if (how == 0)
                begin
                    k = $urandom_range(0, 2);
                    if (k == 0)
                        msg_buf[len - 1 - $urandom_range(0, p - 1)] ^= 8'(1 << $urandom_range(0, 7));
                    else if (k == 1)
                        msg_buf[len - 1] = 8'h00;
                    else
                        msg_buf[len - 1] = 8'($urandom_range(BLOCK + 1, 255));
                end
            end
            SCHEME_M1:
            begin
                k = (how == 0) ? 0 : $urandom_range(0, len);
                for (i = 0; i < len; i++)
                    msg_buf.push_back((i < k) ? rand_byte() : 8'h00);
            end
            SCHEME_M2:
            begin
                k = $urandom_range(0, len - 1);
                for (i = 0; i < len; i++)
                    msg_buf.push_back((i < k) ? rand_byte() : 8'h00);
                // drop the marker for a broken trailer, else place it
                if (how == 0 && $urandom_range(0, 1) == 0)
                    msg_buf[k] = 8'($urandom_range(1, 127));
                else if (how != 0)
                    msg_buf[k] = M2_MARKER;
            end
            default:
                for (i = 0; i < len; i++)
                    msg_buf.push_back(rand_byte());
        endcase
        // occasionally break the block multiple
        if ($urandom_range(0, 7) == 0)
            msg_buf.push_back(rand_byte());
    endtask

    // Result checking and the receiver stall pattern
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (pop && !empty)
        begin
            if (queued_outputs.size() == 0)
                report("result with no request pending", int'(result.out_byte), 0);
            else
            begin
                want = queued_outputs.pop_front();
                if (result.out_byte !== want.out_byte)
                    report("out_byte", int'(result.out_byte), int'(want.out_byte));
                if (result.end_of_message !== want.end_of_message)
                    report("end_of_message", int'(result.end_of_message),
                           int'(want.end_of_message));
                if (result.status !== want.status)
                    report("status", int'(result.status), int'(want.status));
                if (result.result_length !== want.result_length)
                    report("result_length", int'(result.result_length),
                           int'(want.result_length));
            end
        end
        rx_tick++;
        if (rx_tick % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 1) == 0);
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (rx_tick % 8 != 0);
            endcase
        end
    end

    initial
    begin
        int i;
        push = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        errs = 0;
        items_sent = 0;
        burst_left = 0;
        cycles = 0;
        hold_left = 0;
        rx_tick = 0;
        rx_mode = 0;
        hold_req = 1'b0;
        hold_started = 1'b0;
        cur_scheme = SCHEME_BLOCK;
        cur_remove = 1'b0;
        msg_count = '0;
        nonzero_end = '0;
        marker_pos = '0;
        marker_seen = 1'b0;
        for (i = 0; i < BLOCK; i++)
            tail_bytes[i] = 8'h00;

        plan = '{
            '{1'b0, SCHEME_BLOCK,   1'b0, 8'hFF, 1'b1, 1'b1, STATUS_LENGTH, 17'd0},
            '{1'b1, SCHEME_PKCS7,   1'b0, 8'h00, 1'b1, 1'b1, STATUS_OK,     17'd16},
            '{1'b1, SCHEME_M1,      1'b0, 8'hFF, 1'b0, 1'b0, STATUS_OK,     17'd0},
            '{1'b0, SCHEME_M1,      1'b0, 8'h00, 1'b1, 1'b1, STATUS_OK,     17'd16},
            '{1'b1, SCHEME_M2,      1'b0, 8'h80, 1'b1, 1'b1, STATUS_OK,     17'd16},
            '{1'b1, SCHEME_STREAM,  1'b0, 8'h5A, 1'b1, 1'b1, STATUS_OK,     17'd1},
            '{1'b1, SCHEME_SPARE_5, 1'b0, 8'hA5, 1'b1, 1'b1, STATUS_OK,     17'd1},
            '{1'b1, SCHEME_SPARE_6, 1'b1, 8'h01, 1'b1, 1'b1, STATUS_OK,     17'd1},
            '{1'b1, SCHEME_SPARE_7, 1'b1, 8'h7F, 1'b1, 1'b1, STATUS_OK,     17'd1},
            '{1'b1, SCHEME_BLOCK,   1'b1, 8'h10, 1'b1, 1'b1, STATUS_LENGTH, 17'd0},
            '{1'b1, SCHEME_PKCS7,   1'b1, 8'h01, 1'b1, 1'b1, STATUS_LENGTH, 17'd0},
            '{1'b1, SCHEME_M1,      1'b1, 8'h00, 1'b1, 1'b1, STATUS_LENGTH, 17'd0},
            '{1'b1, SCHEME_M2,      1'b1, 8'h80, 1'b1, 1'b1, STATUS_LENGTH, 17'd0},
            '{1'b1, SCHEME_STREAM,  1'b1, 8'h00, 1'b1, 1'b1, STATUS_OK,     17'd1},
            '{1'b1, SCHEME_PKCS7,   1'b0, 8'h11, 1'b0, 1'b0, STATUS_OK,     17'd0},
            '{1'b0, SCHEME_PKCS7,   1'b0, 8'h22, 1'b0, 1'b0, STATUS_OK,     17'd0},
            '{1'b0, SCHEME_PKCS7,   1'b0, 8'h33, 1'b0, 1'b0, STATUS_OK,     17'd0},
            // switch to M2 inside the message; padding follows the new scheme
            '{1'b1, SCHEME_M2,      1'b0, 8'h44, 1'b1, 1'b1, STATUS_OK,     17'd16}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spare indexes must leave both registers at their reset values
        write_reg(REG_SPARE_2, 3'd7, 1'b1);
        write_reg(REG_SPARE_3, 3'd5, 1'b0);

        for (i = 0; i < NUM_STEPS; i++)
        begin
            if (plan[i].set_cfg)
            begin
                wait_idle();
                write_reg(REG_PAD_SCHEME, plan[i].scheme, 1'b1);
                write_reg(REG_REMOVE_PADDING, {2'b00, plan[i].remove}, 1'b0);
            end
            send_byte('{data_byte: plan[i].data_byte, last_byte: plan[i].last_byte},
                      plan[i].typed, plan[i].status, plan[i].length);
        end

        // long receiver hold-off while a long message keeps coming
        hold_req <= 1'b1;
        msg_buf.delete();
        for (i = 0; i < 40; i++)
            msg_buf.push_back(8'($urandom_range(0, 255)));
        send_message();

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_reg(REG_PAD_SCHEME, 3'($urandom_range(0, 7)), 1'b1);
                write_reg(REG_REMOVE_PADDING, 3'($urandom_range(0, 7)), 1'b0);
            end
            build_message();
            send_message();
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (errs == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
